/* hdl/sorted_table_with_cross_read_assert.svh */
// ----------------------------------------------------------------------------
// Sorted table assertion macros
// Concurrent assertion shorthands used by the sorted table top level. They
// sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_WITH_CROSS_READ_ASSERT_SVH
`define SORTED_TABLE_WITH_CROSS_READ_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define STC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sorted table: invariant violated");

// The consequent holds at the same edge as the antecedent.
`define STC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted table: implication violated");

// The consequent holds at the next edge after the antecedent.
`define STC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted table: next-cycle implication violated");

`endif

/* hdl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted table package
// Operation and status codes, the fixed position width and the control
// struct broadcast from the sequencer to the row of cells.
// ----------------------------------------------------------------------------
package stc_pkg;

  // Width of the read position field.
  localparam int POS_W = 6;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_INSERT     = 2'd0,
    FUNC_REMOVE     = 2'd1,
    FUNC_READ_ASC   = 2'd2,
    FUNC_READ_CROSS = 2'd3
  } stc_func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_BAD_INDEX = 2'd3
  } stc_status_e;

  // Broadcast control for the cells.
  typedef struct packed {
    logic load;  // capture compare flags against the incoming beat
    logic ins;   // apply an insert shift
    logic rem;   // apply a remove shift
  } stc_ctrl_t;

endpackage

/* hdl/stc_req_if.sv */
// ----------------------------------------------------------------------------
// Sorted table request channel
// Valid/ready channel carrying one operation beat into the table.
// ----------------------------------------------------------------------------
interface stc_req_if #(
  parameter int VALUE_WIDTH = 32
);
  import stc_pkg::*;

  logic                   valid;
  logic                   ready;
  stc_func_e              func;
  logic [VALUE_WIDTH-1:0] value;
  logic [POS_W-1:0]       position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink   (input valid, input func, input value, input position, output ready);

endinterface

/* hdl/stc_rsp_if.sv */
// ----------------------------------------------------------------------------
// Sorted table response channel
// Valid/ready channel carrying one result beat out of the table.
// ----------------------------------------------------------------------------
interface stc_rsp_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 7
);
  import stc_pkg::*;

  logic                   valid;
  logic                   ready;
  stc_status_e            status;
  logic [VALUE_WIDTH-1:0] data;
  logic [COUNT_WIDTH-1:0] count;

  modport source (output valid, output status, output data, output count, input ready);
  modport sink   (input valid, input status, input data, input count, output ready);

endinterface

/* hdl/sorted_table_with_cross_read.sv */
// ----------------------------------------------------------------------------
// Sorted table with cross read
// Ascending multiset of signed values held in a row of compare-and-shift
// cells, with insert, remove and two read orders by position.
// ----------------------------------------------------------------------------
// Each request beat is handled in an accept cycle and an apply cycle: in the
// accept cycle every cell compares its entry with the beat and latches its
// flags, and in the apply state that follows the cells shift by one place
// toward the left or the right neighbor while the read data and found flag
// are gathered over the row into the response register. The request side is
// ready again in the cycle right after the apply cycle, so a new beat is not
// taken until the previous one has been applied; the apply cycle waits only
// while an earlier response beat is still held unread. Reset clears the fill
// count; the entries themselves hold no reset value and are never read beyond the fill count.
module sorted_table_with_cross_read #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stc_req_if.sink   req_i,
  stc_rsp_if.source rsp_o
);
  import stc_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic                   state_q, state_d;
  stc_func_e              op_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic                   bad_q;
  logic [CNT_W-1:0]       count_q, count_d;

  logic                   rsp_valid_q;
  stc_status_e            status_q;
  logic [VALUE_WIDTH-1:0] data_q;
  logic [CNT_W-1:0]       rsp_count_q;

  logic                   req_fire, slot_free, apply_fire, full, found;
  logic [CMP_W-1:0]       pos_ext, cnt_ext, rank_c;
  logic [VALUE_WIDTH-1:0] cell_value, rd_data;
  stc_status_e            status_d;
  logic [VALUE_WIDTH-1:0] data_d;
  stc_ctrl_t              ctrl;

  logic [VALUE_WIDTH-1:0] entry_w [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_w    [CAPACITY];
  logic [CAPACITY-1:0]    gt_w, eq_w;

  // Handshake control.
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign apply_fire  = (state_q == ST_APPLY) && slot_free;

  // Map the read position to a rank in ascending order.
  assign pos_ext = CMP_W'(req_i.position);
  assign cnt_ext = CMP_W'(count_q);
  always_comb begin
    rank_c = pos_ext;
    if (req_i.func == FUNC_READ_CROSS) begin
      if (req_i.position[0]) begin
        rank_c = cnt_ext - CMP_W'(1) - (pos_ext >> 1);
      end else begin
        rank_c = pos_ext >> 1;
      end
    end
  end

  // Cells compare against the live beat in the accept cycle.
  assign cell_value = req_fire ? req_i.value : value_q;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign found      = |eq_w;

  assign ctrl.load = req_fire;
  assign ctrl.ins  = apply_fire && (op_q == FUNC_INSERT) && !full;
  assign ctrl.rem  = apply_fire && (op_q == FUNC_REMOVE) && found;

  // Row of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_entry, right_entry;
    logic                   left_gt;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_inner_l
      assign left_entry = entry_w[i-1];
      assign left_gt    = gt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner_r
      assign right_entry = entry_w[i+1];
    end

    stc_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .CMP_W       (CMP_W),
      .INDEX       (i)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .value_i       (cell_value),
      .count_i       (count_q),
      .rank_i        (rank_c),
      .left_entry_i  (left_entry),
      .left_gt_i     (left_gt),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[i]),
      .gt_o          (gt_w[i]),
      .eq_o          (eq_w[i]),
      .rd_o          (rd_w[i])
    );
  end

  // Gather the selected entry; at most one cell drives nonzero data.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | rd_w[i];
    end
  end

  // Result and count update for the apply cycle.
  always_comb begin
    status_d = STATUS_OK;
    data_d   = '0;
    count_d  = count_q;
    unique case (op_q)
      FUNC_INSERT: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      FUNC_REMOVE: begin
        if (found) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = STATUS_NOT_FOUND;
        end
      end
      FUNC_READ_ASC, FUNC_READ_CROSS: begin
        if (bad_q) begin
          status_d = STATUS_BAD_INDEX;
        end else begin
          data_d = rd_data;
        end
      end
      default: status_d = STATUS_OK;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (req_fire) state_d = ST_APPLY;
      ST_APPLY: if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply_fire) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q    <= req_i.func;
      value_q <= req_i.value;
      bad_q   <= (pos_ext >= cnt_ext);
    end
  end

  // Response register.
  always_ff @(posedge clk_i) begin
    if (apply_fire) begin
      status_q    <= status_d;
      data_q      <= data_d;
      rsp_count_q <= count_d;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = status_q;
  assign rsp_o.data   = data_q;
  assign rsp_o.count  = rsp_count_q;

  `include "sorted_table_with_cross_read_assert.svh"

  `STC_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY))
  `STC_ASSERT_NEXT(a_accept_to_apply, req_fire, state_q == ST_APPLY)
  `STC_ASSERT_NEXT(a_insert_grows, ctrl.ins, count_q == $past(count_q) + CNT_W'(1))
  `STC_ASSERT_IMPLIES(a_error_no_data, rsp_valid_q && (status_q != STATUS_OK), data_q == '0)

endmodule

/* hdl/stc_cell.sv */
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one table entry. On a request beat it compares its entry with the
// broadcast value and position; on the apply cycle it shifts in from the
// left neighbor (insert) or the right neighbor (remove).
// ----------------------------------------------------------------------------
module stc_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = 7,
  parameter int CMP_W       = 7,
  parameter int INDEX       = 0
) (
  input  logic                   clk_i,
  input  stc_pkg::stc_ctrl_t     ctrl_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [CMP_W-1:0]       rank_i,
  input  logic [VALUE_WIDTH-1:0] left_entry_i,
  input  logic                   left_gt_i,
  input  logic [VALUE_WIDTH-1:0] right_entry_i,
  output logic [VALUE_WIDTH-1:0] entry_o,
  output logic                   gt_o,
  output logic                   eq_o,
  output logic [VALUE_WIDTH-1:0] rd_o
);
  import stc_pkg::*;

  logic [VALUE_WIDTH-1:0] entry_q, entry_d;
  logic                   gt_q, ge_q, eq_q, sel_q;
  logic                   occupied;

  // An entry at or beyond the fill count acts as plus infinity for insert.
  assign occupied = (CNT_W'(INDEX) < count_i);

  // Compare flags are captured with the request beat.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      gt_q  <= !occupied || ($signed(entry_q) > $signed(value_i));
      ge_q  <= occupied && ($signed(entry_q) >= $signed(value_i));
      eq_q  <= occupied && (entry_q == value_i);
      sel_q <= (CMP_W'(INDEX) == rank_i);
    end
  end

  // Shift selection: insert opens a gap at the first greater entry,
  // remove closes the gap at the first matching entry.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && gt_q) begin
      entry_d = left_gt_i ? left_entry_i : value_i;
    end else if (ctrl_i.rem && ge_q) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign gt_o    = gt_q;
  assign eq_o    = eq_q;
  assign rd_o    = sel_q ? entry_q : '0;

endmodule

/* tb/sv/sorted_table_with_cross_read_test.sv */
// ----------------------------------------------------------------------------
// Sorted table with cross read testbench
// Drives insert, remove and both read orders through the request channel and
// checks every response beat against a sorted queue kept alongside the block.
// Covers the empty table, the extreme values, duplicates, a full table and
// random traffic under three patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module sorted_table_with_cross_read_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stc_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 7;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  typedef logic signed [VALUE_W-1:0] entry_t;

  localparam entry_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam entry_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  // One response beat as the table should report it.
  typedef struct packed {
    stc_status_e          status;
    logic [VALUE_W-1:0]   data;
    logic [COUNT_W-1:0]   count;
  } result_t;

  logic clk_i;
  logic rst_ni;

  stc_req_if #(.VALUE_WIDTH(VALUE_W)) req_bus ();
  stc_rsp_if #(.VALUE_WIDTH(VALUE_W), .COUNT_WIDTH(COUNT_W)) rsp_bus ();

  sorted_table_with_cross_read #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Shadow copy of the table contents, kept in ascending order.
  entry_t  table_q[$];
  result_t pending_results[$];

  int src_idle_pct;
  int sink_stall_pct;
  int mismatch_count;
  int result_index;
  int cycle_count;

  // Clock with a 12 ns period.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Apply one operation to the shadow table and return the response it causes.
  function automatic result_t apply_to_table(stc_func_e op, entry_t v,
                                             logic [POS_W-1:0] pos);
    result_t r;
    int      slot;
    int      rank;
    r.status = STATUS_OK;
    r.data   = '0;
    slot     = 0;
    rank     = 0;
    case (op)
      FUNC_INSERT: begin
        if (table_q.size() >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          // New value goes after every equal entry.
          while (slot < table_q.size() && table_q[slot] <= v) slot++;
          table_q.insert(slot, v);
        end
      end
      FUNC_REMOVE: begin
        while (slot < table_q.size() && table_q[slot] != v) slot++;
        if (slot >= table_q.size()) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          table_q.delete(slot);
        end
      end
      default: begin
        if (int'(pos) >= table_q.size()) begin
          r.status = STATUS_BAD_INDEX;
        end else begin
          // Cross order alternates between the low end and the high end.
          if (op == FUNC_READ_ASC) begin
            rank = int'(pos);
          end else if (!pos[0]) begin
            rank = int'(pos >> 1);
          end else begin
            rank = table_q.size() - 1 - ((int'(pos) - 1) >> 1);
          end
          r.data = table_q[rank];
        end
      end
    endcase
    r.count = COUNT_W'(table_q.size());
    return r;
  endfunction

  // Send one request beat, with random sender gaps, and record its response.
  task automatic send_op(stc_func_e op, entry_t v, logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.func     <= op;
    req_bus.value    <= v;
    req_bus.position <= pos;
    do @(posedge clk_i); while (!req_bus.ready);
    pending_results.insert(pending_results.size(), apply_to_table(op, v, pos));
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding response has come back.
  task automatic wait_for_results();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Reads and a remove on the empty table.
  task automatic test_empty_table();
    send_op(FUNC_READ_ASC, '0, '0);
    send_op(FUNC_READ_CROSS, '0, '1);
    send_op(FUNC_REMOVE, 5, '0);
  endtask

  // Extreme values, duplicates, every read order and the not-found and bad-index codes.
  task automatic test_extreme_values();
    send_op(FUNC_INSERT, VALUE_MIN, '0);
    send_op(FUNC_INSERT, VALUE_MAX, '1);
    send_op(FUNC_INSERT, 0, '0);
    send_op(FUNC_INSERT, -1, '1);
    send_op(FUNC_INSERT, VALUE_MAX, '0);
    send_op(FUNC_INSERT, 7, '0);
    send_op(FUNC_READ_ASC, '0, 0);
    send_op(FUNC_READ_ASC, '0, 5);
    send_op(FUNC_READ_ASC, '0, 6);
    for (int k = 0; k < 6; k++) send_op(FUNC_READ_CROSS, '0, k);
    send_op(FUNC_REMOVE, 12345, '0);
    send_op(FUNC_REMOVE, VALUE_MAX, '0);
    send_op(FUNC_READ_CROSS, '0, 1);
    send_op(FUNC_REMOVE, VALUE_MIN, '0);
    send_op(FUNC_READ_ASC, '0, 0);
  endtask

  // Fill the table, push one insert past capacity, then empty it again.
  task automatic test_full_table();
    while (table_q.size() < CAPACITY) send_op(FUNC_INSERT, $urandom, $urandom);
    send_op(FUNC_INSERT, $urandom, $urandom);
    send_op(FUNC_READ_ASC, '0, '1);
    send_op(FUNC_READ_CROSS, '0, '1);
    send_op(FUNC_READ_CROSS, '0, 62);
    send_op(FUNC_READ_CROSS, '0, 0);
    while (table_q.size() != 0) begin
      if ($urandom_range(0, 3) == 0) begin
        send_op(FUNC_READ_CROSS, '0, $urandom_range(0, table_q.size() - 1));
      end else begin
        send_op(FUNC_REMOVE, table_q[$urandom_range(0, table_q.size() - 1)], $urandom);
      end
    end
  endtask

  // Random mix; insert_pct steers whether the table tends to grow or shrink.
  task automatic test_random_traffic(int n, int insert_pct);
    int               roll;
    entry_t           v;
    stc_func_e        op;
    logic [POS_W-1:0] pos;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      pos  = $urandom;
      // Small values collide often, which exercises duplicates and removes.
      case ($urandom_range(0, 9))
        0:          v = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
        1, 2, 3, 4: v = $urandom_range(0, 8) - 4;
        default:    v = $urandom;
      endcase
      if (roll < insert_pct) begin
        op = FUNC_INSERT;
      end else if (roll < insert_pct + 20) begin
        op = FUNC_REMOVE;
        if (table_q.size() != 0 && $urandom_range(0, 3) != 0) begin
          v = table_q[$urandom_range(0, table_q.size() - 1)];
        end
      end else begin
        op = $urandom_range(0, 1) ? FUNC_READ_CROSS : FUNC_READ_ASC;
        if (table_q.size() != 0 && $urandom_range(0, 4) != 0) begin
          pos = $urandom_range(0, table_q.size() - 1);
        end
      end
      send_op(op, v, pos);
    end
  endtask

  // Receiver stalls, redrawn at every falling edge.
  always @(negedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Compare each response beat with the oldest pending result.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("beat %0d: response with none pending: status %s data %h count %0d",
                   result_index, rsp_bus.status.name(), rsp_bus.data, rsp_bus.count);
        end
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.status !== want.status || rsp_bus.data !== want.data ||
            rsp_bus.count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("beat %0d: expected %s %h %0d, got %s %h %0d",
                     result_index, want.status.name(), want.data, want.count,
                     rsp_bus.status.name(), rsp_bus.data, rsp_bus.count);
          end
        end
      end
      result_index++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_table_with_cross_read regression: fail");
      $finish;
    end
  end

  initial begin
    mismatch_count   = 0;
    result_index     = 0;
    cycle_count      = 0;
    src_idle_pct     = 29;
    sink_stall_pct   = 57;
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.func     = FUNC_INSERT;
    req_bus.value    = '0;
    req_bus.position = '0;
    rsp_bus.ready    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Sender gaps light, receiver stalls heavy.
    test_empty_table();
    test_extreme_values();
    test_random_traffic(160, 55);
    wait_for_results();

    // Sender gaps heavy, receiver stalls light.
    src_idle_pct   = 57;
    sink_stall_pct = 29;
    test_full_table();
    test_random_traffic(160, 35);

    // Back to back in both directions.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_traffic(170, 45);

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("sorted_table_with_cross_read regression: pass");
    end else begin
      $display("sorted_table_with_cross_read regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/stc_pkg.sv
hdl/stc_req_if.sv
hdl/stc_rsp_if.sv
hdl/stc_cell.sv
hdl/sorted_table_with_cross_read.sv
tb/sv/sorted_table_with_cross_read_test.sv
